@@ hw/rtl/edft_pkg.sv @@
// ----------------------------------------------------------------------------
// edft_pkg
// Shared constants, types and helpers of the EDF tick scheduler.
// ----------------------------------------------------------------------------
package edft_pkg;

  localparam int MAX_TASKS  = 8;
  localparam int TIME_WIDTH = 32;

  localparam int ABS_W   = TIME_WIDTH + 1;
  localparam int SLOT_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W   = $clog2(MAX_TASKS + 1);
  localparam int VAL_W   = 16;
  localparam int TCNT_W  = 4;
  localparam int CMD_W   = 2;
  localparam int IN_SLOT_W = 3;
  localparam int OUT_TICK_W = 32;

  localparam logic [TIME_WIDTH-1:0] NOW_MAX = {TIME_WIDTH{1'b1}};
  localparam logic [ABS_W-1:0]      ABS_MAX = {ABS_W{1'b1}};

  typedef logic [TIME_WIDTH-1:0] now_t;
  typedef logic [ABS_W-1:0]      abs_t;
  typedef logic [VAL_W-1:0]      val_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  typedef struct packed {
    val_t rem;
    abs_t dl;
    logic miss;
    logic cand;
  } slot_upd_t;

  typedef struct packed {
    val_t rem;
    logic done;
    abs_t next_rel;
  } retire_t;

  function automatic abs_t sat_abs(input logic [ABS_W:0] v);
    abs_t r;
    if (v > {1'b0, ABS_MAX}) r = ABS_MAX;
    else                     r = v[ABS_W-1:0];
    return r;
  endfunction

endpackage

@@ hw/rtl/edft_slot_eval.sv @@
// ----------------------------------------------------------------------------
// edft_slot_eval
// Per-slot step of a tick: release, miss marking and deadline compare.
// ----------------------------------------------------------------------------
module edft_slot_eval (
  input  edft_pkg::now_t      now,
  input  edft_pkg::val_t      exec_val,
  input  edft_pkg::val_t      dl_val,
  input  edft_pkg::val_t      rem,
  input  edft_pkg::abs_t      rel_time,
  input  edft_pkg::abs_t      dl_time,
  input  logic                miss,
  input  logic                found,
  input  edft_pkg::abs_t      best_dl,
  output edft_pkg::slot_upd_t upd
);
  import edft_pkg::*;

  logic rel_hit;
  val_t rem_rel;
  abs_t dl_rel;
  logic miss_rel;
  abs_t now_ext;

  assign now_ext = ABS_W'(now);
  assign rel_hit = (rel_time == now_ext);

  always_comb begin
    rem_rel  = rel_hit ? exec_val : rem;
    dl_rel   = rel_hit ? sat_abs((ABS_W+1)'(now) + (ABS_W+1)'(dl_val)) : dl_time;
    miss_rel = rel_hit ? 1'b0 : miss;
    upd.rem  = rem_rel;
    upd.dl   = dl_rel;
    upd.miss = miss_rel | ((dl_rel == now_ext) && (rem_rel != '0));
    upd.cand = (rem_rel != '0) && (!found || (dl_rel < best_dl));
  end

endmodule

@@ hw/rtl/edft_retire.sv @@
// ----------------------------------------------------------------------------
// edft_retire
// Charge one tick to the running slot and work out its next release.
// ----------------------------------------------------------------------------
module edft_retire (
  input  edft_pkg::now_t    now,
  input  edft_pkg::val_t    rem,
  input  edft_pkg::val_t    exec_val,
  input  edft_pkg::val_t    period_val,
  output edft_pkg::retire_t ret
);
  import edft_pkg::*;

  val_t gap;

  always_comb begin
    gap          = period_val - exec_val;
    ret.rem      = rem - 1'b1;
    ret.done     = (ret.rem == '0);
    if (period_val < exec_val) ret.next_rel = ABS_MAX;
    else ret.next_rel = sat_abs((ABS_W+1)'(now) + (ABS_W+1)'(1) + (ABS_W+1)'(gap));
  end

endmodule

@@ hw/rtl/edf_tick_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// edf_tick_scheduler_top
// Earliest-deadline-first tick scheduler over a small task table.
// ----------------------------------------------------------------------------
// Load and start beats are taken in S_IDLE and leave the block ready. A tick
// beat is accepted in S_IDLE; S_SCAN steps each of the min(task_count,
// MAX_TASKS) taking-part slots through the shared slot evaluation unit
// (release, miss marking, deadline compare); S_DONE charges the winner and
// presents the result, waiting while the output register is still full. Only tick
// beats give a result beat; the block is not ready while a tick is in progress.
module edf_tick_scheduler_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,    // task_count
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,       // slot[2:0], exec_time[18:3],
                                      // rel_deadline[34:19], period[50:35]
  input  logic [1:0]  in_tuser,       // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,      // run_slot[2:0], missed[3], tick_time[35:4]
  output logic        out_tuser       // idle[0]
);
  import edft_pkg::*;

  state_t state_r, state_nxt;
  logic [TCNT_W-1:0] task_count_r;
  now_t now_r;
  logic [CNT_W-1:0] idx_r, idx_nxt, count;
  logic [SLOT_W-1:0] best_r, rd_idx, ld_idx;
  abs_t best_dl_r;
  logic found_r;

  val_t exec_r [MAX_TASKS];
  val_t dltab_r [MAX_TASKS];
  val_t period_r [MAX_TASKS];
  val_t rem_r [MAX_TASKS];
  abs_t rel_r [MAX_TASKS];
  abs_t dl_r [MAX_TASKS];
  logic miss_r [MAX_TASKS];

  logic out_tvalid_r;
  logic [39:0] out_tdata_r;
  logic out_tuser_r;

  cmd_t cmd;
  logic in_beat, out_free, finish;
  slot_upd_t upd;
  retire_t ret;

  assign cmd       = cmd_t'(in_tuser);
  assign in_tready = (state_r == S_IDLE);
  assign in_beat   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign finish    = (state_r == S_DONE) && out_free;
  assign ld_idx    = SLOT_W'(in_tdata[IN_SLOT_W-1:0]);

  assign count  = (32'(task_count_r) > MAX_TASKS) ? CNT_W'(MAX_TASKS) : CNT_W'(task_count_r);
  assign idx_nxt = idx_r + 1'b1;
  assign rd_idx = (state_r == S_DONE) ? best_r : idx_r[SLOT_W-1:0];

  edft_slot_eval u_eval (
    .now      (now_r),
    .exec_val (exec_r[rd_idx]),
    .dl_val   (dltab_r[rd_idx]),
    .rem      (rem_r[rd_idx]),
    .rel_time (rel_r[rd_idx]),
    .dl_time  (dl_r[rd_idx]),
    .miss     (miss_r[rd_idx]),
    .found    (found_r),
    .best_dl  (best_dl_r),
    .upd      (upd)
  );

  edft_retire u_retire (
    .now        (now_r),
    .rem        (rem_r[rd_idx]),
    .exec_val   (exec_r[rd_idx]),
    .period_val (period_r[rd_idx]),
    .ret        (ret)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_beat && (cmd == CMD_TICK)) begin
          state_nxt = (count == '0) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx_nxt == count) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      task_count_r <= '0;
      now_r        <= '0;
      idx_r        <= '0;
      best_r       <= '0;
      best_dl_r    <= '0;
      found_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        exec_r[i]   <= '0;
        dltab_r[i]  <= '0;
        period_r[i] <= '0;
        rem_r[i]    <= '0;
        rel_r[i]    <= '0;
        dl_r[i]     <= '0;
        miss_r[i]   <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) task_count_r <= cfg_wr_data;

      if (in_beat) begin
        idx_r   <= '0;
        found_r <= 1'b0;
        case (cmd)
          CMD_LOAD: begin
            if (32'(in_tdata[IN_SLOT_W-1:0]) < MAX_TASKS) begin
              exec_r[ld_idx]   <= in_tdata[18:3];
              dltab_r[ld_idx]  <= in_tdata[34:19];
              period_r[ld_idx] <= in_tdata[50:35];
            end
          end
          CMD_START: begin
            for (int i = 0; i < MAX_TASKS; i++) begin
              rem_r[i]  <= exec_r[i];
              rel_r[i]  <= '0;
              dl_r[i]   <= ABS_W'(dltab_r[i]);
              miss_r[i] <= 1'b0;
            end
            now_r <= '0;
          end
          default: ;
        endcase
      end

      if (state_r == S_SCAN) begin
        rem_r[rd_idx]  <= upd.rem;
        dl_r[rd_idx]   <= upd.dl;
        miss_r[rd_idx] <= upd.miss;
        if (upd.cand) begin
          best_r    <= rd_idx;
          best_dl_r <= upd.dl;
          found_r   <= 1'b1;
        end
        idx_r <= idx_nxt;
      end

      if (finish) begin
        if (found_r) begin
          rem_r[rd_idx] <= ret.rem;
          if (ret.done) rel_r[rd_idx] <= ret.next_rel;
        end
        out_tvalid_r <= 1'b1;
        out_tdata_r  <= {4'b0, OUT_TICK_W'(now_r),
                         found_r & miss_r[rd_idx],
                         found_r ? IN_SLOT_W'(best_r) : IN_SLOT_W'(0)};
        out_tuser_r  <= !found_r;
        if (now_r < NOW_MAX) now_r <= now_r + 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

@@ hw/rtl/edft_checker.sv @@
// ----------------------------------------------------------------------------
// edft_checker
// Port-level checks of the EDF tick scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module edft_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser
);
  import edft_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat dropped or changed while stalled");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[3:0] == 4'd0)
    else $error("idle result carries a slot or a miss");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == CMD_TICK) |=> !in_tready)
    else $error("ready after a tick beat");

  a_short_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser != CMD_TICK) |=> in_tready)
    else $error("not ready after a load or start beat");

endmodule

bind edf_tick_scheduler_top edft_checker u_edft_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
